// ----- hw/rtl/adt_pkg.sv -----
package adt_pkg;

  localparam int ADT_SAMPLE_BITS = 16;
  localparam int TIME_W = 32;
  localparam int SHOCK_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SHOCK_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP_MS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_GAP_MS = 2'd3;

  localparam logic [CFG_W-1:0] RST_SHOCK_THRESHOLD = 16'd6144;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS = 16'd50;
  localparam logic [CFG_W-1:0] RST_MIN_GAP_MS = 16'd50;
  localparam logic [CFG_W-1:0] RST_MAX_GAP_MS = 16'd400;
  localparam logic [SHOCK_W-1:0] RST_PREV_MAGNITUDE = 16'd4096;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } event_t;

  typedef struct packed {
    logic               kind;
    logic [TIME_W-1:0]  time_ms;
    logic [SHOCK_W-1:0] mag;
  } tap_req_t;

  typedef struct packed {
    event_t             event_res;
    logic [SHOCK_W-1:0] shock;
  } tap_res_t;

endpackage

// ----- hw/rtl/adt_isqrt.sv -----
module adt_isqrt import adt_pkg::*; #(
  parameter int RW = ADT_SAMPLE_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] operand,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int NW = 2 * RW;
  localparam int CW = $clog2(RW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] n;
  logic [RW+1:0] rem;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          ge;

  assign rem_sh = {rem[RW-1:0], n[NW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        n    <= operand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        n    <= {n[NW-3:0], 2'b00};
        rem  <= ge ? (rem_sh - trial) : rem_sh;
        root <= {root[RW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/adt_tap_eval.sv -----
module adt_tap_eval import adt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   req_go,
  input  tap_req_t               req,
  output tap_res_t               res
);

  logic [CFG_W-1:0]   shock_threshold;
  logic [CFG_W-1:0]   debounce_ms;
  logic [CFG_W-1:0]   min_gap_ms;
  logic [CFG_W-1:0]   max_gap_ms;

  logic               primed, primed_next;
  logic [SHOCK_W-1:0] prev_magnitude, prev_magnitude_next;
  logic [TIME_W-1:0]  last_tap_ms, last_tap_ms_next;
  logic [TIME_W-1:0]  first_tap_ms, first_tap_ms_next;
  logic [SHOCK_W-1:0] first_tap_shock, first_tap_shock_next;
  logic               awaiting_second, awaiting_second_next;

  logic [TIME_W-1:0]  since_first;
  logic [TIME_W-1:0]  since_last;
  logic [SHOCK_W-1:0] delta;
  logic               expired;

  assign since_first = req.time_ms - first_tap_ms;
  assign since_last  = req.time_ms - last_tap_ms;
  assign delta = (req.mag >= prev_magnitude) ? (req.mag - prev_magnitude)
                                             : (prev_magnitude - req.mag);
  assign expired = awaiting_second && (since_first > TIME_W'(max_gap_ms));

  always_comb begin
    primed_next          = primed;
    prev_magnitude_next  = prev_magnitude;
    last_tap_ms_next     = last_tap_ms;
    first_tap_ms_next    = first_tap_ms;
    first_tap_shock_next = first_tap_shock;
    awaiting_second_next = awaiting_second;
    res.event_res        = EV_NONE;
    res.shock            = '0;
    if (req.kind == KIND_TICK) begin
      if (expired) begin
        awaiting_second_next = 1'b0;
        res.event_res        = EV_SINGLE;
      end
    end else if (!primed) begin
      primed_next         = 1'b1;
      prev_magnitude_next = req.mag;
    end else begin
      prev_magnitude_next = req.mag;
      res.shock           = delta;
      if (expired) begin
        awaiting_second_next = 1'b0;
        res.event_res        = EV_SINGLE;
      end
      if (delta >= shock_threshold && since_last >= TIME_W'(debounce_ms)) begin
        last_tap_ms_next = req.time_ms;
        if (!awaiting_second_next) begin
          awaiting_second_next = 1'b1;
          first_tap_ms_next    = req.time_ms;
          first_tap_shock_next = delta;
        end else if (since_first >= TIME_W'(min_gap_ms) &&
                     since_first <= TIME_W'(max_gap_ms)) begin
          awaiting_second_next = 1'b0;
          res.event_res        = EV_DOUBLE;
          res.shock = (first_tap_shock > delta) ? first_tap_shock : delta;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shock_threshold <= RST_SHOCK_THRESHOLD;
      debounce_ms     <= RST_DEBOUNCE_MS;
      min_gap_ms      <= RST_MIN_GAP_MS;
      max_gap_ms      <= RST_MAX_GAP_MS;
      primed          <= 1'b0;
      prev_magnitude  <= RST_PREV_MAGNITUDE;
      last_tap_ms     <= '0;
      first_tap_ms    <= '0;
      first_tap_shock <= '0;
      awaiting_second <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SHOCK_THRESHOLD: shock_threshold <= cfg_data;
          REG_DEBOUNCE_MS:     debounce_ms <= cfg_data;
          REG_MIN_GAP_MS:      min_gap_ms <= cfg_data;
          REG_MAX_GAP_MS:      max_gap_ms <= cfg_data;
          default: ;
        endcase
      end
      if (req_go) begin
        primed          <= primed_next;
        prev_magnitude  <= prev_magnitude_next;
        last_tap_ms     <= last_tap_ms_next;
        first_tap_ms    <= first_tap_ms_next;
        first_tap_shock <= first_tap_shock_next;
        awaiting_second <= awaiting_second_next;
      end
    end
  end

endmodule

// ----- hw/rtl/accel_double_tap_detector_unit.sv -----
// Path: a sample goes from transfer to result through the shared squarer, the
// one-bit-per-cycle square root, a step to take the root and a decision step;
// a tick goes straight to the decision step.
// Flow: one item at a time; s_tready is high only while idle, so a new item is not
// taken until the last one is through; a held result stalls the decision.
// Reset: synchronous rst restores the register defaults and clears the detector state.
module accel_double_tap_detector_unit import adt_pkg::*; #(
  parameter int SAMPLE_BITS = ADT_SAMPLE_BITS,
  localparam int IN_W = ((TIME_W + 3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,  // time_ms, accel_x, accel_y, accel_z, zero pad
  input  logic                   s_tuser,  // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SHOCK_W-1:0]     m_tdata,  // shock
  output logic [1:0]             m_tuser,  // event_res
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = 2 * SAMPLE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_EVAL
  } state_t;

  state_t             state;
  logic [1:0]         sq_cnt;
  logic               kind;
  logic [TIME_W-1:0]  time_ms;
  logic [SB-1:0]      accel_x, accel_y, accel_z;
  logic [SB-1:0]      sel;
  logic [SB-1:0]      mul_a;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      acc;
  logic [PW-1:0]      acc_next;
  logic [SHOCK_W-1:0] mag;
  logic               root_start;
  logic               root_done;
  logic [SB-1:0]      root;
  logic               eval_go;
  tap_req_t           req;
  tap_res_t           res;

  always_comb begin
    case (sq_cnt)
      2'd0:    sel = accel_x;
      2'd1:    sel = accel_y;
      default: sel = accel_z;
    endcase
  end

  assign mul_a      = sel[SB-1] ? (~sel + 1'b1) : sel;
  assign acc_next   = acc + prod;
  assign root_start = (state == ST_SQUARE) && (sq_cnt == 2'd3);
  assign eval_go    = (state == ST_EVAL) && (!m_tvalid || m_tready);
  assign s_tready   = (state == ST_IDLE);

  assign req.kind    = kind;
  assign req.time_ms = time_ms;
  assign req.mag     = mag;

  adt_isqrt #(.RW(SB)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (acc_next),
    .done    (root_done),
    .root    (root)
  );

  adt_tap_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_go    (eval_go),
    .req       (req),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sq_cnt   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (eval_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind    <= s_tuser;
            time_ms <= s_tdata[TIME_W-1:0];
            accel_x <= s_tdata[TIME_W +: SB];
            accel_y <= s_tdata[TIME_W + SB +: SB];
            accel_z <= s_tdata[TIME_W + 2 * SB +: SB];
            acc     <= '0;
            prod    <= '0;
            sq_cnt  <= '0;
            state   <= (s_tuser == KIND_TICK) ? ST_EVAL : ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          acc    <= acc_next;
          prod   <= PW'(mul_a) * PW'(mul_a);
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 2'd3) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            mag   <= (32'(root) > 32'hFFFF) ? 16'hFFFF : SHOCK_W'(root);
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eval_go) begin
            m_tuser  <= res.event_res;
            m_tdata  <= res.shock;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/adt_checker.sv -----
module adt_checker import adt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [SHOCK_W-1:0] m_tdata,
  input logic [1:0]         m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("invalid event code");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_tick_no_shock: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_TICK) ##1 (!m_tvalid || m_tready)
      |=> m_tvalid && (m_tdata == '0))
    else $error("tick result carries shock");

endmodule

bind accel_double_tap_detector_unit adt_checker u_adt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
